FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             seen;
    logic [VAL_W-1:0] value;
  } chain_t;

  typedef struct packed {
    logic             go_hit;
    logic             go_miss;
    logic [KEY_W-1:0] key;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_cell.sv
// One slot of the recency chain: holds a pair, compares its key, shifts from its neighbor.
`default_nettype none

module lkv_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lkv_pkg::ctl_t  ctl,
  input  wire lkv_pkg::entry_t prev,
  input  wire lkv_pkg::chain_t chain_in,
  input  wire logic           miss_sel,
  output lkv_pkg::entry_t     entry,
  output lkv_pkg::chain_t     chain_out,
  output logic                hit
);

  logic                      valid;
  logic [lkv_pkg::KEY_W-1:0] key;
  logic [lkv_pkg::VAL_W-1:0] value;
  logic                      take;

  assign hit = valid && (key == ctl.key);

  assign chain_out.seen  = chain_in.seen | hit;
  assign chain_out.value = chain_in.value | (hit ? value : '0);

  assign take = (ctl.go_hit && (chain_in.seen || hit)) || (ctl.go_miss && miss_sel);

  assign entry.valid = valid;
  assign entry.key   = key;
  assign entry.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key   <= prev.key;
      value <= prev.value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request register, slot chain and result register.
//
// Usage:
//   Slave stream s_*: one beat per request. s_tuser is the opcode (get or put),
//   s_tdata carries lookup_key in bits 31:0 and write_value in bits 63:32.
//   Master stream m_*: one beat per request, in order. m_tuser is found,
//   m_tdata is read_value (hit value on get, all ones on get miss, zero on put).
//   Capacity: cfg_we writes cfg_wdata into the capacity register; 0 acts as 1,
//   values above the slot count act as the slot count. Write only while idle.
// Timing:
//   A request is accepted in the idle state; in the execute state all slots
//   compare the key in parallel and, on a hit or a put miss, the chain shifts
//   back and the pair enters the front slot. The result beat is registered as
//   execute ends, and no new request is taken until the state returns to idle.
//   The slot-chain update is the limiting step.
// Reset:
//   rst empties the store, sets capacity to 16 and drops any pending beat.
// Backpressure:
//   A held result stays on m_* until taken; the next request waits in the
//   request register and the chain holds until the result register frees up.
`default_nettype none

module lru_key_value_cache (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata, // lookup_key, write_value
  input  wire logic                              s_tuser,  // opcode
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [lkv_pkg::VAL_W-1:0]              m_tdata,  // read_value
  output logic                                   m_tuser,  // found
  input  wire logic                              cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0]         cfg_wdata // capacity_in_use
);

  localparam int N = lkv_pkg::MAX_ENTRIES;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                        state;
  logic                        req_op;
  logic [lkv_pkg::KEY_W-1:0]   req_key;
  logic [lkv_pkg::VAL_W-1:0]   req_val;
  logic [lkv_pkg::CAP_W-1:0]   cap_reg;
  logic [lkv_pkg::OCC_W-1:0]   occ;
  logic [lkv_pkg::OCC_W-1:0]   occ_next;
  logic [lkv_pkg::OCC_W-1:0]   eff_cap;
  logic [lkv_pkg::OCC_W-1:0]   miss_pos;
  logic                        exec_fire;
  logic                        found;
  logic                        s_fire;

  lkv_pkg::ctl_t   ctl;
  lkv_pkg::entry_t new_entry;
  lkv_pkg::entry_t entry_w [N];
  lkv_pkg::entry_t prev_w  [N];
  lkv_pkg::chain_t chain_w [N+1];
  logic [N-1:0]    hit_vec;
  logic [N-1:0]    valid_vec;
  logic [N-1:0]    miss_sel;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign exec_fire = (state == ST_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = lkv_pkg::OCC_W'(1);
    end else if (32'(cap_reg) > 32'(N)) begin
      eff_cap = lkv_pkg::OCC_W'(N);
    end else begin
      eff_cap = lkv_pkg::OCC_W'(cap_reg);
    end
  end

  // Evict the last slot when full, so the insert shifts one slot less.
  always_comb begin
    if (occ >= eff_cap) begin
      miss_pos = occ - lkv_pkg::OCC_W'(1);
      occ_next = occ;
    end else begin
      miss_pos = occ;
      occ_next = occ + lkv_pkg::OCC_W'(1);
    end
  end

  assign found = chain_w[0].seen;

  assign ctl.key     = req_key;
  assign ctl.go_hit  = exec_fire && found;
  assign ctl.go_miss = exec_fire && !found && (req_op == lkv_pkg::OP_PUT);

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = req_key;
  assign new_entry.value = (req_op == lkv_pkg::OP_PUT) ? req_val : chain_w[0].value;

  assign chain_w[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_w[i] = new_entry;
    end else begin : g_body
      assign prev_w[i] = entry_w[i-1];
    end
    assign miss_sel[i]  = (lkv_pkg::OCC_W'(i) <= miss_pos);
    assign valid_vec[i] = entry_w[i].valid;

    lkv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev      (prev_w[i]),
      .chain_in  (chain_w[i+1]),
      .miss_sel  (miss_sel[i]),
      .entry     (entry_w[i]),
      .chain_out (chain_w[i]),
      .hit       (hit_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      occ      <= '0;
      cap_reg  <= lkv_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (exec_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctl.go_miss) begin
        occ <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_op  <= s_tuser;
      req_key <= s_tdata[lkv_pkg::KEY_W-1:0];
      req_val <= s_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W];
    end
    if (exec_fire) begin
      m_tuser <= found;
      if (req_op == lkv_pkg::OP_PUT) begin
        m_tdata <= '0;
      end else if (found) begin
        m_tdata <= chain_w[0].value;
      end else begin
        m_tdata <= '1;
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= 32'(N))
    else $error("occupancy above slot count");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(occ))
    else $error("valid slots disagree with occupancy");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("key present in more than one slot");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> m_tvalid && (state == ST_IDLE))
    else $error("result beat missing after execute");

endmodule

`default_nettype wire

FILE: tb/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: directed and random get/put streams.
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int HANG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 66;

  class lru_store_tracker;
    typedef struct {
      logic             found;
      logic [VAL_W-1:0] value;
    } reply_t;

    logic [KEY_W-1:0] keys [MAX_ENTRIES];
    logic [VAL_W-1:0] values [MAX_ENTRIES];
    int               occupancy;
    logic [CAP_W-1:0] capacity;
    reply_t           replies_due [$];
    int               mismatches;
    int               gets;
    int               puts;
    int               hits;
    int               evictions;

    function new();
      occupancy = 0;
      capacity = CAP_RESET;
      mismatches = 0;
      gets = 0;
      puts = 0;
      hits = 0;
      evictions = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int usable_slots();
      if (capacity == 0) return 1;
      if (capacity > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(capacity);
    endfunction

    function void bring_to_front(int pos, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      for (int i = pos; i > 0; i--) begin
        keys[i] = keys[i-1];
        values[i] = values[i-1];
      end
      keys[0] = key;
      values[0] = val;
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int     slot;
      reply_t r;
      slot = -1;
      for (int i = 0; i < occupancy; i++)
        if (slot < 0 && keys[i] == key) slot = i;
      if (op == OP_GET) begin
        gets++;
        if (slot >= 0) begin
          r.found = 1'b1;
          r.value = values[slot];
          hits++;
          bring_to_front(slot, key, values[slot]);
        end else begin
          r.found = 1'b0;
          r.value = '1;
        end
      end else begin
        puts++;
        r.value = '0;
        if (slot >= 0) begin
          r.found = 1'b1;
          hits++;
          bring_to_front(slot, key, val);
        end else begin
          r.found = 1'b0;
          if (occupancy >= usable_slots() && occupancy > 0) begin
            occupancy--;
            evictions++;
          end
          if (occupancy < MAX_ENTRIES) begin
            bring_to_front(occupancy, key, val);
            occupancy++;
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    function void flag(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_reply(logic found, logic [VAL_W-1:0] value);
      reply_t want;
      if (replies_due.size() == 0) begin
        flag("reply beat with no request pending", '0, value);
        return;
      end
      want = replies_due.pop_front();
      if (found !== want.found) flag("found", VAL_W'(want.found), VAL_W'(found));
      if (value !== want.value) flag("read_value", want.value, value);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata = '0; // lookup_key, write_value
  logic                   s_tuser = OP_GET; // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [VAL_W-1:0]       m_tdata; // read_value
  logic                   m_tuser; // found
  logic                   cfg_we = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;

  lru_store_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int capacity_writes = 0;
  int hang_count = 0;

  always #10 clk = ~clk;

  lru_key_value_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) tracker.check_reply(m_tuser, m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("no beat for %0d cycles", HANG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {val, key};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, key, val);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(cap);
    capacity_writes++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int mode);
    logic [KEY_W-1:0] key_pool [24];
    int               pool_n;
    int               pick;
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    set_idling(mode);
    pool_n = tracker.usable_slots() + 1 + $urandom_range(4);
    for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      if (pick < 85)
        key = key_pool[$urandom_range(pool_n - 1)];
      else if (pick < 92)
        key = key_pool[$urandom_range(pool_n - 1)] ^ (32'd1 << $urandom_range(31));
      else
        key = $urandom;
      send_request($urandom_range(1) ? OP_PUT : OP_GET, key, $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [8];
    phase_caps = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd5, 5'd16, 5'd17, 5'd9};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
    send_request(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);

    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0001, 32'h0000_0011);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0002, 32'h0000_0022);
    send_request(OP_PUT, 32'hAAAA_AAAA, 32'hDEAD_BEEF);

    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0003, 32'h0000_0033);
    send_request(OP_PUT, 32'h0000_0004, 32'h0000_0044);
    send_request(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0004, 32'h0000_0000);

    for (int p = 0; p < 8; p++) random_phase(phase_caps[p], p % 4);

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d gets and %0d puts: %0d hits, %0d evictions",
             tracker.gets, tracker.puts, tracker.hits, tracker.evictions);
    $display("over %0d capacity settings, %0d mismatches",
             capacity_writes, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
